// File: design/rmas_pkg.sv
// ----------------------------------------------------------------------------
// Running median absolute sum package
// Shared types, codes, sizes and helper functions for the sorted cell chain.
// ----------------------------------------------------------------------------
package rmas_pkg;

    localparam int CAPACITY   = 1024;
    localparam int VALUE_BITS = 32;
    localparam int DELTA_BITS = 32;
    localparam int SUM_BITS   = 42;
    localparam int COUNT_BITS = 11;
    localparam int LEN_BITS   = $clog2(CAPACITY + 1);
    localparam int GROUP      = 32;
    localparam int NGROUP     = (CAPACITY + GROUP - 1) / GROUP;

    typedef logic signed [VALUE_BITS-1:0] t_value;

    typedef enum logic [0:0] {
        CMD_INSERT = 1'b0,
        CMD_ERASE  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_FULL   = 2'd1,
        STATUS_ABSENT = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INS1,
        OP_INS2,
        OP_DEL1,
        OP_DEL2,
        OP_POP
    } t_cell_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN2,
        ST_STEP1,
        ST_STEP2,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        COST_NONE,
        COST_ADD,
        COST_SUB
    } t_cost;

    typedef struct packed {
        t_cmd   command;
        t_value value;
    } t_in;

    typedef struct packed {
        logic [DELTA_BITS-1:0] delta;
        logic [SUM_BITS-1:0]   total_sum;
        t_value                median_low;
        t_value                median_high;
        logic [COUNT_BITS-1:0] stored_count;
        t_status               status;
    } t_out;

    typedef struct packed {
        t_cell_op op;
        logic     desc;
        t_value   val;
        t_value   key;
    } t_cell_cmd;

    typedef struct packed {
        logic   stay_l1;
        logic   stay_l2;
        t_value val_l1;
        t_value val_l2;
        t_value val_r1;
        t_value val_r2;
    } t_nbr;

    typedef struct packed {
        logic any;
        logic two;
    } t_match;

    function automatic logic precedes(input logic desc, input t_value a, input t_value b);
        precedes = desc ? (a > b) : (a < b);
    endfunction

    function automatic logic [VALUE_BITS-1:0] gap(input t_value lo, input t_value hi,
                                                  input t_value x);
        logic signed [VALUE_BITS:0] dl;
        logic signed [VALUE_BITS:0] dh;
        dl = $signed({lo[VALUE_BITS-1], lo}) - $signed({x[VALUE_BITS-1], x});
        dh = $signed({x[VALUE_BITS-1], x}) - $signed({hi[VALUE_BITS-1], hi});
        if (x < lo) begin
            gap = dl[VALUE_BITS-1:0];
        end else if (x > hi) begin
            gap = dh[VALUE_BITS-1:0];
        end else begin
            gap = '0;
        end
    endfunction

endpackage

// File: design/rmas_cell.sv
// ----------------------------------------------------------------------------
// Sorted chain cell
// Holds one entry of a sorted half and takes its next value from itself or
// from a neighbor according to the broadcast command.
// ----------------------------------------------------------------------------
module rmas_cell (
    input  logic               i_clk,
    input  rmas_pkg::t_cell_cmd i_cmd,
    input  logic               i_valid,
    input  rmas_pkg::t_nbr     i_nbr,
    output rmas_pkg::t_value   o_val,
    output logic               o_stay,
    output logic               o_eq
);

    rmas_pkg::t_value r_val;
    rmas_pkg::t_value n_val;
    logic             w_shift;

    assign o_stay  = i_valid && !rmas_pkg::precedes(i_cmd.desc, i_cmd.val, r_val);
    assign w_shift = !rmas_pkg::precedes(i_cmd.desc, r_val, i_cmd.val);
    assign o_eq    = i_valid && (r_val == i_cmd.key);
    assign o_val   = r_val;

    always_comb begin
        case (i_cmd.op)
            rmas_pkg::OP_INS1: begin
                if (o_stay) begin
                    n_val = r_val;
                end else if (i_nbr.stay_l1) begin
                    n_val = i_cmd.val;
                end else begin
                    n_val = i_nbr.val_l1;
                end
            end
            rmas_pkg::OP_INS2: begin
                if (o_stay) begin
                    n_val = r_val;
                end else if (i_nbr.stay_l1 || i_nbr.stay_l2) begin
                    n_val = i_cmd.val;
                end else begin
                    n_val = i_nbr.val_l2;
                end
            end
            rmas_pkg::OP_DEL1: n_val = w_shift ? i_nbr.val_r1 : r_val;
            rmas_pkg::OP_DEL2: n_val = w_shift ? i_nbr.val_r2 : r_val;
            rmas_pkg::OP_POP:  n_val = i_nbr.val_r1;
            default:           n_val = r_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

// File: design/rmas_half.sv
// ----------------------------------------------------------------------------
// Sorted half
// A row of cells kept in sorted order, with its length and a registered
// two-level search for entries equal to the key.
// ----------------------------------------------------------------------------
module rmas_half (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rmas_pkg::t_cell_cmd              i_cmd,
    output rmas_pkg::t_value                 o_head,
    output logic [rmas_pkg::LEN_BITS-1:0]    o_len,
    output rmas_pkg::t_match                 o_match
);

    localparam int PAD = rmas_pkg::NGROUP * rmas_pkg::GROUP;

    logic [rmas_pkg::LEN_BITS-1:0] r_len;
    logic [rmas_pkg::LEN_BITS-1:0] n_len;
    rmas_pkg::t_value              w_val  [rmas_pkg::CAPACITY];
    logic [rmas_pkg::CAPACITY-1:0] w_stay;
    logic [rmas_pkg::CAPACITY-1:0] w_eq;
    logic [PAD-1:0]                w_eq_pad;
    logic [PAD-1:0]                w_two_pad;
    logic [rmas_pkg::NGROUP-1:0]   r_grp_any;
    logic [rmas_pkg::NGROUP-1:0]   r_grp_two;
    rmas_pkg::t_match              r_match;

    for (genvar i = 0; i < rmas_pkg::CAPACITY; i++) begin : g_cell
        rmas_pkg::t_nbr w_nbr;
        logic           w_valid;

        assign w_valid = rmas_pkg::LEN_BITS'(i) < r_len;

        if (i >= 1) begin : g_l1
            assign w_nbr.stay_l1 = w_stay[i-1];
            assign w_nbr.val_l1  = w_val[i-1];
        end else begin : g_l1_edge
            assign w_nbr.stay_l1 = 1'b1;
            assign w_nbr.val_l1  = '0;
        end
        if (i >= 2) begin : g_l2
            assign w_nbr.stay_l2 = w_stay[i-2];
            assign w_nbr.val_l2  = w_val[i-2];
        end else begin : g_l2_edge
            assign w_nbr.stay_l2 = 1'b1;
            assign w_nbr.val_l2  = '0;
        end
        if (i + 1 < rmas_pkg::CAPACITY) begin : g_r1
            assign w_nbr.val_r1 = w_val[i+1];
            assign w_two_pad[i] = w_eq[i] && w_eq[i+1];
        end else begin : g_r1_edge
            assign w_nbr.val_r1 = '0;
            assign w_two_pad[i] = 1'b0;
        end
        if (i + 2 < rmas_pkg::CAPACITY) begin : g_r2
            assign w_nbr.val_r2 = w_val[i+2];
        end else begin : g_r2_edge
            assign w_nbr.val_r2 = '0;
        end

        assign w_eq_pad[i] = w_eq[i];

        rmas_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (i_cmd),
            .i_valid (w_valid),
            .i_nbr   (w_nbr),
            .o_val   (w_val[i]),
            .o_stay  (w_stay[i]),
            .o_eq    (w_eq[i])
        );
    end

    for (genvar p = rmas_pkg::CAPACITY; p < PAD; p++) begin : g_pad
        assign w_eq_pad[p]  = 1'b0;
        assign w_two_pad[p] = 1'b0;
    end

    always_comb begin
        case (i_cmd.op)
            rmas_pkg::OP_INS1: n_len = r_len + rmas_pkg::LEN_BITS'(1);
            rmas_pkg::OP_INS2: n_len = r_len + rmas_pkg::LEN_BITS'(2);
            rmas_pkg::OP_DEL1: n_len = r_len - rmas_pkg::LEN_BITS'(1);
            rmas_pkg::OP_POP:  n_len = r_len - rmas_pkg::LEN_BITS'(1);
            rmas_pkg::OP_DEL2: n_len = r_len - rmas_pkg::LEN_BITS'(2);
            default:           n_len = r_len;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else begin
            r_len <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < rmas_pkg::NGROUP; g++) begin
            r_grp_any[g] <= |w_eq_pad[g*rmas_pkg::GROUP +: rmas_pkg::GROUP];
            r_grp_two[g] <= |w_two_pad[g*rmas_pkg::GROUP +: rmas_pkg::GROUP];
        end
        r_match.any <= |r_grp_any;
        r_match.two <= |r_grp_two;
    end

    assign o_head  = w_val[0];
    assign o_len   = r_len;
    assign o_match = r_match;

endmodule

// File: design/running_median_abs_sum.sv
// ----------------------------------------------------------------------------
// Running median absolute sum
// Keeps a bounded multiset as two sorted cell chains and reports the minimum
// sum of absolute deviations after every insert or erase.
// ----------------------------------------------------------------------------
// The input channel (i_valid, o_ready, i_data) takes one item, an insert or
// an erase of a signed value. The output channel (o_valid, i_ready, o_data)
// returns one result item per input item: the cost change, the running
// total, the median interval, the stored count and a status code.
// The block works on one item at a time. An insert passes STEP1, then STEP2
// when needed, then DONE, where the result register is loaded; an erase
// first passes SCAN and SCAN2 for the registered two-level search for
// matching entries across the cell chains. STEP2 is taken to move an entry
// between the halves. The next item is accepted in IDLE, the state that
// follows DONE once the result is loaded.
// Reset empties the store and clears the total; entry contents are not
// cleared. While the receiver stalls, the result is held and the block may
// accept and work on one more item, then waits until the result is taken.
// ----------------------------------------------------------------------------
module running_median_abs_sum (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  rmas_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output rmas_pkg::t_out o_data
);

    rmas_pkg::t_state              r_state;
    rmas_pkg::t_state              n_state;
    rmas_pkg::t_cmd                r_cmd;
    rmas_pkg::t_cmd                n_cmd;
    rmas_pkg::t_value              r_x;
    rmas_pkg::t_value              n_x;
    rmas_pkg::t_status             r_status;
    rmas_pkg::t_status             n_status;
    logic [rmas_pkg::DELTA_BITS-1:0] r_delta;
    logic [rmas_pkg::DELTA_BITS-1:0] n_delta;
    rmas_pkg::t_cost               r_mode;
    rmas_pkg::t_cost               n_mode;
    logic                          r_pend_l;
    logic                          n_pend_l;
    rmas_pkg::t_cell_op            r_pend_op;
    rmas_pkg::t_cell_op            n_pend_op;
    rmas_pkg::t_value              r_pend_val;
    rmas_pkg::t_value              n_pend_val;
    logic [rmas_pkg::SUM_BITS-1:0] r_total;
    logic [rmas_pkg::SUM_BITS-1:0] n_total;
    logic                          r_out_valid;
    logic                          n_out_valid;
    rmas_pkg::t_out                r_out;
    rmas_pkg::t_out                n_out;

    rmas_pkg::t_cell_cmd           w_cmd_l;
    rmas_pkg::t_cell_cmd           w_cmd_u;
    rmas_pkg::t_value              w_head_l;
    rmas_pkg::t_value              w_head_u;
    logic [rmas_pkg::LEN_BITS-1:0] w_len_l;
    logic [rmas_pkg::LEN_BITS-1:0] w_len_u;
    rmas_pkg::t_match              w_match_l;
    rmas_pkg::t_match              w_match_u;

    logic w_empty;
    logic w_full;
    logic w_inside;
    logic w_both;
    logic w_present;
    logic w_two_step;
    logic w_out_free;
    logic [rmas_pkg::DELTA_BITS-1:0] w_del;

    rmas_half u_lower (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd_l),
        .o_head  (w_head_l),
        .o_len   (w_len_l),
        .o_match (w_match_l)
    );

    rmas_half u_upper (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd_u),
        .o_head  (w_head_u),
        .o_len   (w_len_u),
        .o_match (w_match_u)
    );

    assign w_empty    = (w_len_l == '0);
    assign w_full     = (w_len_l >= rmas_pkg::LEN_BITS'(rmas_pkg::CAPACITY));
    assign w_inside   = !w_empty && (w_head_l <= r_x) && (r_x <= w_head_u);
    assign w_both     = w_match_l.any && w_match_u.any;
    assign w_present  = w_both || w_match_l.two || w_match_u.two;
    assign w_two_step = (r_cmd == rmas_pkg::CMD_INSERT) ?
                        (!w_full && !w_empty && !w_inside) : (w_present && !w_both);
    assign w_out_free = !r_out_valid || i_ready;
    assign w_del      = (r_mode == rmas_pkg::COST_SUB) ?
                        rmas_pkg::DELTA_BITS'(rmas_pkg::gap(w_head_l, w_head_u, r_x)) :
                        r_delta;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rmas_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = (i_data.command == rmas_pkg::CMD_ERASE) ?
                              rmas_pkg::ST_SCAN : rmas_pkg::ST_STEP1;
                end
            end
            rmas_pkg::ST_SCAN:  n_state = rmas_pkg::ST_SCAN2;
            rmas_pkg::ST_SCAN2: n_state = rmas_pkg::ST_STEP1;
            rmas_pkg::ST_STEP1: n_state = w_two_step ? rmas_pkg::ST_STEP2 : rmas_pkg::ST_DONE;
            rmas_pkg::ST_STEP2: n_state = rmas_pkg::ST_DONE;
            rmas_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = rmas_pkg::ST_IDLE;
                end
            end
            default: n_state = rmas_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        w_cmd_l      = '{op: rmas_pkg::OP_HOLD, desc: 1'b1, val: r_x, key: r_x};
        w_cmd_u      = '{op: rmas_pkg::OP_HOLD, desc: 1'b0, val: r_x, key: r_x};
        n_cmd        = r_cmd;
        n_x          = r_x;
        n_status     = r_status;
        n_delta      = r_delta;
        n_mode       = r_mode;
        n_pend_l     = r_pend_l;
        n_pend_op    = r_pend_op;
        n_pend_val   = r_pend_val;
        n_total      = r_total;
        n_out_valid  = r_out_valid && !i_ready;
        n_out        = r_out;
        o_ready      = 1'b0;
        unique case (r_state)
            rmas_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_cmd = i_data.command;
                    n_x   = i_data.value;
                end
            end
            rmas_pkg::ST_STEP1: begin
                n_status = rmas_pkg::STATUS_OK;
                n_mode   = rmas_pkg::COST_NONE;
                n_delta  = '0;
                if (r_cmd == rmas_pkg::CMD_INSERT) begin
                    if (w_full) begin
                        n_status = rmas_pkg::STATUS_FULL;
                    end else if (w_empty || w_inside) begin
                        w_cmd_l.op = rmas_pkg::OP_INS1;
                        w_cmd_u.op = rmas_pkg::OP_INS1;
                    end else begin
                        n_mode     = rmas_pkg::COST_ADD;
                        n_delta    = rmas_pkg::DELTA_BITS'(rmas_pkg::gap(w_head_l, w_head_u, r_x));
                        n_pend_op  = rmas_pkg::OP_INS2;
                        n_pend_val = r_x;
                        if (r_x < w_head_l) begin
                            w_cmd_l.op  = rmas_pkg::OP_POP;
                            w_cmd_u.op  = rmas_pkg::OP_INS1;
                            w_cmd_u.val = w_head_l;
                            n_pend_l    = 1'b1;
                        end else begin
                            w_cmd_u.op  = rmas_pkg::OP_POP;
                            w_cmd_l.op  = rmas_pkg::OP_INS1;
                            w_cmd_l.val = w_head_u;
                            n_pend_l    = 1'b0;
                        end
                    end
                end else begin
                    if (!w_present) begin
                        n_status = rmas_pkg::STATUS_ABSENT;
                    end else if (w_both) begin
                        w_cmd_l.op = rmas_pkg::OP_DEL1;
                        w_cmd_u.op = rmas_pkg::OP_DEL1;
                    end else begin
                        n_mode    = rmas_pkg::COST_SUB;
                        n_pend_op = rmas_pkg::OP_INS1;
                        if (w_match_l.two) begin
                            w_cmd_l.op = rmas_pkg::OP_DEL2;
                            w_cmd_u.op = rmas_pkg::OP_POP;
                            n_pend_l   = 1'b1;
                            n_pend_val = w_head_u;
                        end else begin
                            w_cmd_u.op = rmas_pkg::OP_DEL2;
                            w_cmd_l.op = rmas_pkg::OP_POP;
                            n_pend_l   = 1'b0;
                            n_pend_val = w_head_l;
                        end
                    end
                end
            end
            rmas_pkg::ST_STEP2: begin
                if (r_pend_l) begin
                    w_cmd_l.op  = r_pend_op;
                    w_cmd_l.val = r_pend_val;
                end else begin
                    w_cmd_u.op  = r_pend_op;
                    w_cmd_u.val = r_pend_val;
                end
            end
            rmas_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    if (r_mode == rmas_pkg::COST_ADD) begin
                        n_total = r_total + rmas_pkg::SUM_BITS'(w_del);
                    end else if (r_mode == rmas_pkg::COST_SUB) begin
                        n_total = r_total - rmas_pkg::SUM_BITS'(w_del);
                    end
                    n_out.delta        = (r_mode == rmas_pkg::COST_NONE) ? '0 : w_del;
                    n_out.total_sum    = n_total;
                    n_out.median_low   = w_empty ? '0 : w_head_l;
                    n_out.median_high  = w_empty ? '0 : w_head_u;
                    n_out.stored_count = rmas_pkg::COUNT_BITS'(w_len_l);
                    n_out.status       = r_status;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rmas_pkg::ST_IDLE;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_x        <= n_x;
        r_status   <= n_status;
        r_delta    <= n_delta;
        r_mode     <= n_mode;
        r_pend_l   <= n_pend_l;
        r_pend_op  <= n_pend_op;
        r_pend_val <= n_pend_val;
        r_out      <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_len_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == rmas_pkg::ST_IDLE |-> w_len_l == w_len_u)
        else $error("lower and upper halves differ in length");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_len_l <= rmas_pkg::LEN_BITS'(rmas_pkg::CAPACITY))
        else $error("stored count exceeds capacity");

    a_interval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rmas_pkg::ST_IDLE && !w_empty) |-> w_head_l <= w_head_u)
        else $error("median interval is inverted");

    a_done_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rmas_pkg::ST_DONE && w_out_free) |=> r_state == rmas_pkg::ST_IDLE)
        else $error("result loaded without returning to idle");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.status == rmas_pkg::STATUS_FULL) |->
        o_data.stored_count == rmas_pkg::COUNT_BITS'(rmas_pkg::CAPACITY))
        else $error("full status reported below capacity");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Running median absolute sum testbench
// Drives insert and erase items through random source gaps and sink stalls,
// keeps its own copy of the two sorted halves, and checks every result item.
// ----------------------------------------------------------------------------
module tb_top;

    localparam longint CYCLE_LIMIT = 2000000;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_valid = 1'b0;
    logic           i_ready = 1'b0;
    rmas_pkg::t_in  i_data = '0;
    logic           o_ready;
    logic           o_valid;
    rmas_pkg::t_out o_data;

    running_median_abs_sum uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_data(i_data), .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    always #1 i_clk = ~i_clk;

    longint                        halves[2][rmas_pkg::CAPACITY+1];
    int                            held = 0;
    logic [rmas_pkg::SUM_BITS-1:0] cost = '0;
    rmas_pkg::t_out                pending[$];
    int                            errors = 0;
    int                            n_sent = 0;
    int                            n_checked = 0;
    int                            n_full = 0;
    int                            n_absent = 0;
    int                            stall_left = 0;
    longint                        cycles = 0;
    bit                            sending_done = 1'b0;

    function automatic void place(int h, int n, longint x);
        int i = 0;
        while (i < n && halves[h][i] <= x) i++;
        for (int j = n; j > i; j--) halves[h][j] = halves[h][j-1];
        halves[h][i] = x;
    endfunction

    function automatic void drop(int h, int n, int i);
        for (int j = i; j < n - 1; j++) halves[h][j] = halves[h][j+1];
    endfunction

    function automatic int locate(int h, int n, longint x);
        int i = 0;
        while (i < n && halves[h][i] != x) i++;
        return i;
    endfunction

    function automatic int occurrences(int h, int n, longint x);
        int c = 0;
        for (int i = 0; i < n; i++) if (halves[h][i] == x) c++;
        return c;
    endfunction

    function automatic longint distance(longint lo, longint hi, longint x);
        longint dl = lo > x ? lo - x : x - lo;
        longint dh = hi > x ? hi - x : x - hi;
        return dl < dh ? dl : dh;
    endfunction

    function automatic rmas_pkg::t_out median_step(rmas_pkg::t_cmd cmd, rmas_pkg::t_value v);
        rmas_pkg::t_out    r;
        longint            x = v;
        longint            d = 0;
        longint            a, b, plo, phi;
        int                n = held;
        int                cl, cu;
        rmas_pkg::t_status st = rmas_pkg::STATUS_OK;
        if (cmd == rmas_pkg::CMD_INSERT) begin
            if (n >= rmas_pkg::CAPACITY) begin
                st = rmas_pkg::STATUS_FULL;
            end else if (n == 0) begin
                halves[0][0] = x;
                halves[1][0] = x;
                n = 1;
            end else begin
                plo = halves[0][n-1];
                phi = halves[1][0];
                place(0, n, x);
                place(1, n, x);
                n++;
                if (!(plo <= x && x <= phi)) begin
                    if (halves[0][n-1] > halves[1][0]) begin
                        a = halves[0][n-1];
                        b = halves[1][0];
                        drop(0, n, n - 1);
                        drop(1, n, 0);
                        place(1, n - 1, a);
                        place(0, n - 1, b);
                    end
                    d = distance(plo, phi, x);
                    cost = cost + d[rmas_pkg::SUM_BITS-1:0];
                end
            end
        end else begin
            cl = occurrences(0, n, x);
            cu = occurrences(1, n, x);
            if (n == 0 || cl + cu < 2) begin
                st = rmas_pkg::STATUS_ABSENT;
            end else if (cl != 0 && cu != 0) begin
                drop(0, n, locate(0, n, x));
                drop(1, n, locate(1, n, x));
                n--;
            end else begin
                if (cl != 0) begin
                    b = halves[1][0];
                    drop(0, n, locate(0, n, x));
                    drop(0, n - 1, locate(0, n - 1, x));
                    drop(1, n, 0);
                    place(0, n - 2, b);
                end else begin
                    a = halves[0][n-1];
                    drop(1, n, locate(1, n, x));
                    drop(1, n - 1, locate(1, n - 1, x));
                    drop(0, n, n - 1);
                    place(1, n - 2, a);
                end
                n--;
                plo = halves[0][n-1];
                phi = halves[1][0];
                if (!(plo <= x && x <= phi)) begin
                    d = distance(plo, phi, x);
                    cost = cost - d[rmas_pkg::SUM_BITS-1:0];
                end
            end
        end
        held = n;
        r.delta        = d[rmas_pkg::DELTA_BITS-1:0];
        r.total_sum    = cost;
        r.median_low   = n ? rmas_pkg::t_value'(halves[0][n-1]) : '0;
        r.median_high  = n ? rmas_pkg::t_value'(halves[1][0]) : '0;
        r.stored_count = n[rmas_pkg::COUNT_BITS-1:0];
        r.status       = st;
        return r;
    endfunction

    function automatic int idle_len();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
                                            : $urandom_range(0, 3);
    endfunction

    // One item: optional gap, then hold valid until the handshake.
    task automatic send(rmas_pkg::t_cmd cmd, rmas_pkg::t_value v, bit typed,
                        rmas_pkg::t_out want);
        rmas_pkg::t_out got;
        int             gap_n = ($urandom_range(0, 3) == 0) ? idle_len() : 0;
        if (gap_n > 0) begin
            i_valid <= 1'b0;
            repeat (gap_n) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= '{command: cmd, value: v};
        do @(posedge i_clk); while (!(i_valid && o_ready));
        got = median_step(cmd, v);
        if (got.status == rmas_pkg::STATUS_FULL) n_full++;
        if (got.status == rmas_pkg::STATUS_ABSENT) n_absent++;
        pending.push_back(typed ? want : got);
        n_sent++;
    endtask

    function automatic rmas_pkg::t_value pick_value();
        case ($urandom_range(0, 9))
            0: return rmas_pkg::t_value'(32'h8000_0000);
            1: return rmas_pkg::t_value'(32'h7fff_ffff);
            2, 3: return rmas_pkg::t_value'($urandom);
            default: return rmas_pkg::t_value'($signed($urandom_range(0, 15)) - 8);
        endcase
    endfunction

    function automatic rmas_pkg::t_value stored_value();
        if (held == 0) return pick_value();
        return rmas_pkg::t_value'(halves[$urandom_range(0, 1)][$urandom_range(0, held - 1)]);
    endfunction

    typedef struct {
        rmas_pkg::t_cmd   cmd;
        rmas_pkg::t_value v;
        bit               typed;
        rmas_pkg::t_out   want;
    } t_row;

    t_row rows[$];

    initial begin
        rmas_pkg::t_out   none;
        rmas_pkg::t_cmd   c;
        rmas_pkg::t_value v;
        none = '0;
        rows.push_back('{rmas_pkg::CMD_ERASE, 5, 1,
                         '{0, 0, 0, 0, 0, rmas_pkg::STATUS_ABSENT}});
        rows.push_back('{rmas_pkg::CMD_INSERT, 0, 1,
                         '{0, 0, 0, 0, 1, rmas_pkg::STATUS_OK}});
        rows.push_back('{rmas_pkg::CMD_INSERT, 32'sh7fff_ffff, 1,
                         '{32'h7fff_ffff, 42'h7fff_ffff, 0, 32'sh7fff_ffff, 2,
                           rmas_pkg::STATUS_OK}});
        rows.push_back('{rmas_pkg::CMD_INSERT, 32'sh8000_0000, 1,
                         '{32'h8000_0000, 42'hffff_ffff, 0, 0, 3, rmas_pkg::STATUS_OK}});
        rows.push_back('{rmas_pkg::CMD_ERASE, 32'sh7fff_ffff, 0, none});
        rows.push_back('{rmas_pkg::CMD_ERASE, 7, 0, none});
        rows.push_back('{rmas_pkg::CMD_INSERT, 0, 0, none});
        rows.push_back('{rmas_pkg::CMD_INSERT, -1, 0, none});
        rows.push_back('{rmas_pkg::CMD_ERASE, 32'sh8000_0000, 0, none});
        rows.push_back('{rmas_pkg::CMD_INSERT, 3, 0, none});
        rows.push_back('{rmas_pkg::CMD_INSERT, 3, 0, none});
        rows.push_back('{rmas_pkg::CMD_ERASE, 0, 0, none});
        rows.push_back('{rmas_pkg::CMD_ERASE, 3, 0, none});
        rows.push_back('{rmas_pkg::CMD_ERASE, -1, 0, none});
        rows.push_back('{rmas_pkg::CMD_INSERT, 32'sh5555_5555, 0, none});
        rows.push_back('{rmas_pkg::CMD_INSERT, 32'shaaaa_aaaa, 0, none});
        rows.push_back('{rmas_pkg::CMD_ERASE, 32'sh5555_5555, 0, none});
        rows.push_back('{rmas_pkg::CMD_ERASE, 32'sh5555_5555, 0, none});

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) send(rows[k].cmd, rows[k].v, rows[k].typed, rows[k].want);

        for (int k = 0; k < 600; k++) begin
            case ($urandom_range(0, 19))
                0, 1, 2:  begin c = rmas_pkg::CMD_ERASE; v = pick_value(); end
                3, 4, 5, 6, 7: begin c = rmas_pkg::CMD_ERASE; v = stored_value(); end
                default:  begin c = rmas_pkg::CMD_INSERT; v = pick_value(); end
            endcase
            send(c, v, 0, none);
        end
        while (held < rmas_pkg::CAPACITY) send(rmas_pkg::CMD_INSERT, pick_value(), 0, none);
        repeat (6) send(rmas_pkg::CMD_INSERT, pick_value(), 0, none);
        for (int k = 0; k < 350; k++) begin
            if ($urandom_range(0, 4) == 0) send(rmas_pkg::CMD_INSERT, pick_value(), 0, none);
            else send(rmas_pkg::CMD_ERASE, ($urandom_range(0, 5) == 0) ? pick_value()
                                                                        : stored_value(),
                      0, none);
        end
        i_valid <= 1'b0;
        sending_done = 1'b1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if ($urandom_range(0, 49) == 0) begin
            stall_left = $urandom_range(20, 80);
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge i_clk) begin
        rmas_pkg::t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending.size() == 0) begin
                $error("result item with no expectation waiting");
                errors++;
            end else begin
                want = pending.pop_front();
                n_checked++;
                if (o_data.delta !== want.delta) begin
                    $error("delta: expected %0d, got %0d", want.delta, o_data.delta);
                    errors++;
                end
                if (o_data.total_sum !== want.total_sum) begin
                    $error("total_sum: expected %0d, got %0d", want.total_sum,
                           o_data.total_sum);
                    errors++;
                end
                if (o_data.median_low !== want.median_low) begin
                    $error("median_low: expected %0d, got %0d", want.median_low,
                           o_data.median_low);
                    errors++;
                end
                if (o_data.median_high !== want.median_high) begin
                    $error("median_high: expected %0d, got %0d", want.median_high,
                           o_data.median_high);
                    errors++;
                end
                if (o_data.stored_count !== want.stored_count) begin
                    $error("stored_count: expected %0d, got %0d", want.stored_count,
                           o_data.stored_count);
                    errors++;
                end
                if (o_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_data.status);
                    errors++;
                end
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout with %0d results outstanding", pending.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        wait (sending_done);
        while (pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (pending.size() != 0) begin
            $error("%0d expected results never arrived", pending.size());
            errors++;
        end
        $display("Sent %0d items, checked %0d results, %0d full and %0d absent cases.",
                 n_sent, n_checked, n_full, n_absent);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
design/rmas_pkg.sv
design/rmas_cell.sv
design/rmas_half.sv
design/running_median_abs_sum.sv
bench/tb_top.sv
